[rtl/mptt_pkg.sv]
`timescale 1ns / 1ps
package mptt_pkg;

  localparam int CAPACITY_DEF  = 64;
  localparam int ID_BITS_DEF   = 16;
  localparam int PRIO_BITS_DEF = 32;

  localparam logic [1:0] ACT_ADD  = 2'd0;
  localparam logic [1:0] ACT_EDIT = 2'd1;
  localparam logic [1:0] ACT_REM  = 2'd2;
  localparam logic [1:0] ACT_EXEC = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_UNKNOWN = 2'd3;

  // cell commands
  localparam logic [1:0] OP_HOLD = 2'd0;
  localparam logic [1:0] OP_SHL  = 2'd1;
  localparam logic [1:0] OP_POP  = 2'd2;
  localparam logic [1:0] OP_INS  = 2'd3;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] task_id;
    logic [15:0] user_id;
    logic [31:0] priority_req;
  } mptt_in_t;

  typedef struct packed {
    logic [15:0] owner;
    logic [1:0]  status;
  } mptt_out_t;

endpackage

[rtl/max_priority_task_table.sv]
`timescale 1ns / 1ps
// channel | direction | handshake            | payload
// req     | in        | req_valid, req_ready | mptt_in_t  (action, task_id, user_id, priority_req)
// rsp     | out       | rsp_valid, rsp_ready | mptt_out_t (owner, status)
//
// entries live in a row of cells kept sorted by priority then task id, largest first.
// execute, also on an empty table, goes from lookup straight to the result; remove and
// rejected items pass lookup and remove; add of a new id lookup, remove and insert; edit and
// add of a present id one lookup, one left shift, one right shift through the row. one item
// is worked on at a time. rst clears the cell valid bits and the control, no clearing pass.
// a finished result waits in the output register; the next item is accepted meanwhile.
module max_priority_task_table
  import mptt_pkg::*;
#(
  parameter int CAPACITY  = CAPACITY_DEF,
  parameter int ID_BITS   = ID_BITS_DEF,
  parameter int PRIO_BITS = PRIO_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  mptt_in_t  req,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output mptt_out_t rsp
);

  localparam int U_LO  = PRIO_BITS;
  localparam int T_LO  = PRIO_BITS + ID_BITS;
  localparam int V_BIT = PRIO_BITS + 2 * ID_BITS;
  localparam int EW    = V_BIT + 1;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_FIND   = 3'd1;
  localparam logic [2:0] S_REMOVE = 3'd2;
  localparam logic [2:0] S_INSERT = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0]           st;
  logic [1:0]           cur_act;
  logic [ID_BITS-1:0]   cur_id;
  logic [ID_BITS-1:0]   cur_user;
  logic [PRIO_BITS-1:0] cur_prio;
  logic                 found;
  logic [ID_BITS-1:0]   muser;
  logic [PRIO_BITS-1:0] mprio;
  logic [1:0]           status;
  logic [15:0]          owner;

  logic [EW-1:0]        ent [CAPACITY];
  logic [CAPACITY-1:0]  sel_v;
  logic [CAPACITY-1:0]  valid_v;
  logic [ID_BITS-1:0]   task_a [CAPACITY];
  logic [ID_BITS-1:0]   user_a [CAPACITY];
  logic [PRIO_BITS-1:0] prio_a [CAPACITY];

  logic                 f_found;
  logic [ID_BITS-1:0]   f_user;
  logic [PRIO_BITS-1:0] f_prio;

  logic [1:0]           cell_op;
  logic [ID_BITS-1:0]   ins_user;
  logic                 out_free;
  logic [31:0]          id_ext;
  logic [31:0]          user_ext;
  logic [31:0]          top_user_ext;

  assign req_ready = (st == S_IDLE);
  assign out_free  = !rsp_valid || rsp_ready;
  assign ins_user  = (cur_act == ACT_EDIT) ? muser : cur_user;
  assign id_ext    = 32'(req.task_id);
  assign user_ext  = 32'(req.user_id);
  assign top_user_ext = 32'(user_a[0]);

  always_comb begin
    cell_op = OP_HOLD;
    case (st)
      S_FIND: begin
        if (cur_act == ACT_EXEC && valid_v[0]) cell_op = OP_POP;
      end
      S_REMOVE: begin
        if (found) cell_op = OP_SHL;
      end
      S_INSERT: cell_op = OP_INS;
      default:  cell_op = OP_HOLD;
    endcase
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [EW-1:0] left_e;
    logic [EW-1:0] right_e;
    logic          prev_sel;

    if (i == 0) begin : g_first
      assign left_e   = '0;
      assign prev_sel = 1'b0;
    end else begin : g_mid
      assign left_e   = ent[i-1];
      assign prev_sel = sel_v[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_e = '0;
    end else begin : g_inner
      assign right_e = ent[i+1];
    end

    mptt_cell #(
      .ID_BITS  (ID_BITS),
      .PRIO_BITS(PRIO_BITS)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .op      (cell_op),
      .cmd_task(cur_id),
      .cmd_user(ins_user),
      .cmd_prio(cur_prio),
      .rm_prio (mprio),
      .prev_sel(prev_sel),
      .left    (left_e),
      .right   (right_e),
      .entry   (ent[i]),
      .sel     (sel_v[i])
    );

    assign valid_v[i] = ent[i][V_BIT];
    assign task_a[i]  = ent[i][T_LO +: ID_BITS];
    assign user_a[i]  = ent[i][U_LO +: ID_BITS];
    assign prio_a[i]  = ent[i][PRIO_BITS-1:0];
  end

  mptt_find #(
    .CAPACITY (CAPACITY),
    .ID_BITS  (ID_BITS),
    .PRIO_BITS(PRIO_BITS)
  ) u_find (
    .valid_v(valid_v),
    .task_a (task_a),
    .user_a (user_a),
    .prio_a (prio_a),
    .id     (cur_id),
    .found  (f_found),
    .user   (f_user),
    .prio   (f_prio)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      if (st == S_DONE && out_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (st)
        S_IDLE: begin
          if (req_valid) begin
            cur_act  <= req.action;
            cur_id   <= id_ext[ID_BITS-1:0];
            cur_user <= user_ext[ID_BITS-1:0];
            cur_prio <= req.priority_req[PRIO_BITS-1:0];
            owner    <= '0;
            status   <= ST_OK;
            st       <= S_FIND;
          end
        end
        S_FIND: begin
          if (cur_act == ACT_EXEC) begin
            if (valid_v[0]) begin
              owner  <= top_user_ext[15:0];
              status <= ST_OK;
            end else begin
              status <= ST_EMPTY;
            end
            st <= S_DONE;
          end else begin
            found <= f_found;
            muser <= f_user;
            mprio <= f_prio;
            st    <= S_REMOVE;
          end
        end
        S_REMOVE: begin
          if (found) begin
            st <= (cur_act == ACT_REM) ? S_DONE : S_INSERT;
          end else if (cur_act == ACT_ADD) begin
            if (valid_v[CAPACITY-1]) begin
              status <= ST_FULL;
              st     <= S_DONE;
            end else begin
              st <= S_INSERT;
            end
          end else begin
            status <= ST_UNKNOWN;
            st     <= S_DONE;
          end
        end
        S_INSERT: st <= S_DONE;
        S_DONE: begin
          if (out_free) begin
            rsp.owner  <= owner;
            rsp.status <= status;
            st         <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/mptt_cell.sv]
`timescale 1ns / 1ps
module mptt_cell
  import mptt_pkg::*;
#(
  parameter int ID_BITS   = ID_BITS_DEF,
  parameter int PRIO_BITS = PRIO_BITS_DEF,
  localparam int T_LO  = PRIO_BITS + ID_BITS,
  localparam int V_BIT = PRIO_BITS + 2 * ID_BITS,
  localparam int EW    = V_BIT + 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [1:0]           op,
  input  logic [ID_BITS-1:0]   cmd_task,
  input  logic [ID_BITS-1:0]   cmd_user,
  input  logic [PRIO_BITS-1:0] cmd_prio,
  input  logic [PRIO_BITS-1:0] rm_prio,
  input  logic                 prev_sel,
  input  logic [EW-1:0]        left,
  input  logic [EW-1:0]        right,
  output logic [EW-1:0]        entry,
  output logic                 sel
);

  logic [EW-1:0]                  ent;
  logic [EW-1:0]                  ent_next;
  logic                           valid;
  logic [PRIO_BITS+ID_BITS-1:0]   key_self;
  logic [PRIO_BITS+ID_BITS-1:0]   rm_key;
  logic [PRIO_BITS+ID_BITS-1:0]   ins_key;
  logic                           rm_sel;

  assign valid    = ent[V_BIT];
  assign key_self = {ent[PRIO_BITS-1:0], ent[T_LO +: ID_BITS]};
  assign rm_key   = {rm_prio, cmd_task};
  assign ins_key  = {cmd_prio, cmd_task};
  assign rm_sel   = !valid || (key_self <= rm_key);
  assign sel      = !valid || (key_self < ins_key);

  always_comb begin
    ent_next = ent;
    case (op)
      OP_SHL: begin
        if (rm_sel) ent_next = right;
      end
      OP_POP: ent_next = right;
      OP_INS: begin
        if (sel) ent_next = prev_sel ? left : {1'b1, cmd_task, cmd_user, cmd_prio};
      end
      default: ent_next = ent;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent[V_BIT] <= 1'b0;
    end else begin
      ent <= ent_next;
    end
  end

  assign entry = ent;

endmodule

[rtl/mptt_find.sv]
`timescale 1ns / 1ps
module mptt_find
  import mptt_pkg::*;
#(
  parameter int CAPACITY  = CAPACITY_DEF,
  parameter int ID_BITS   = ID_BITS_DEF,
  parameter int PRIO_BITS = PRIO_BITS_DEF
) (
  input  logic [CAPACITY-1:0]  valid_v,
  input  logic [ID_BITS-1:0]   task_a [CAPACITY],
  input  logic [ID_BITS-1:0]   user_a [CAPACITY],
  input  logic [PRIO_BITS-1:0] prio_a [CAPACITY],
  input  logic [ID_BITS-1:0]   id,
  output logic                 found,
  output logic [ID_BITS-1:0]   user,
  output logic [PRIO_BITS-1:0] prio
);

  logic [CAPACITY-1:0] hit;

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      hit[i] = valid_v[i] && (task_a[i] == id);
    end
  end

  // at most one entry holds a given id, so an or of the masked fields selects it
  always_comb begin
    user = '0;
    prio = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      user = user | (user_a[i] & {ID_BITS{hit[i]}});
      prio = prio | (prio_a[i] & {PRIO_BITS{hit[i]}});
    end
  end

  assign found = |hit;

endmodule
